// File: hw/rtl/scbc_pkg.sv
// Shared types, opcodes and codes for the stack bytecode constraint checker.
`timescale 1ns / 1ps
`default_nettype none

package scbc_pkg;

	// Fixed field widths
	localparam int VALUE_W    = 32;
	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 8;
	localparam int PROG_LEN_W = 9;
	localparam int GAS_W      = 16;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [GAS_W-1:0] GAS_RESET = 16'hFFFF;

	// Bytecode opcodes
	localparam logic [BYTE_W-1:0] OPC_HALT   = 8'h1A;
	localparam logic [BYTE_W-1:0] OPC_ASSERT = 8'h1B;
	localparam logic [BYTE_W-1:0] OPC_RANGE  = 8'h1D;
	localparam logic [BYTE_W-1:0] OPC_AND    = 8'h26;
	localparam logic [BYTE_W-1:0] OPC_OR     = 8'h27;
	localparam logic [BYTE_W-1:0] OPC_DUP    = 8'h28;
	localparam logic [BYTE_W-1:0] OPC_SWAP   = 8'h29;

	// Item operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_PROG_LEN = 2'd0;
	localparam logic [1:0] REG_GAS      = 2'd1;
	localparam logic [1:0] REG_END_RULE = 2'd2;

	typedef enum logic [1:0] {
		VERDICT_PASS        = 2'd0,
		VERDICT_ASSERT_FAIL = 2'd1,
		VERDICT_GAS_OUT     = 2'd2,
		VERDICT_STACK_ERR   = 2'd3
	} verdict_t;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_FETCH,
		SQ_DECODE,
		SQ_POP,
		SQ_POP_WAIT,
		SQ_EXEC,
		SQ_RANGE2,
		SQ_DUP_WR,
		SQ_SWAP_RD2,
		SQ_SWAP_WR1,
		SQ_SWAP_WR2,
		SQ_END_CHK,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic                      op;
		logic [ADDR_W-1:0]         prog_addr;
		logic [BYTE_W-1:0]         prog_byte;
		logic signed [VALUE_W-1:0] value;
		logic                      last_in_batch;
	} chk_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       batch_failed;
	} res_item_t;

	typedef struct packed {
		logic [PROG_LEN_W-1:0] prog_len;
		logic [GAS_W-1:0]      gas;
		logic                  end_rule;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] value;
	} seq_req_t;

	typedef struct packed {
		logic     idle;
		logic     done;
		verdict_t verdict;
	} seq_rsp_t;

	typedef struct packed {
		logic le;
		logic x_nz;
		logic y_nz;
	} alu_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/scbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module scbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/scbc_alu.sv
// Shared compare unit: signed less-or-equal and zero tests on two words.
`timescale 1ns / 1ps
`default_nettype none

module scbc_alu (
	input  wire logic [scbc_pkg::VALUE_W-1:0] x,
	input  wire logic [scbc_pkg::VALUE_W-1:0] y,
	output scbc_pkg::alu_res_t                res
);

	import scbc_pkg::*;

	// Compare as two's complement, test each operand for zero
	always_comb begin
		res.le   = ($signed(x) <= $signed(y));
		res.x_nz = (x != '0);
		res.y_nz = (y != '0);
	end

endmodule

`default_nettype wire

// File: hw/rtl/scbc_seq.sv
// Interpreter sequencer: program fetch, operand stack and opcode execution.
`timescale 1ns / 1ps
`default_nettype none

module scbc_seq #(
	parameter int PROGRAM_DEPTH = 256,
	parameter int STACK_DEPTH   = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire scbc_pkg::seq_req_t               req,
	input  wire scbc_pkg::cfg_t                   cfg,
	input  wire logic                             take,
	output scbc_pkg::seq_rsp_t                    rsp,
	output logic [$clog2(PROGRAM_DEPTH)-1:0]      prog_raddr,
	input  wire logic [scbc_pkg::BYTE_W-1:0]      prog_rdata
);

	import scbc_pkg::*;

	localparam int AW      = $clog2(PROGRAM_DEPTH);
	localparam int LEN_MAX = (PROGRAM_DEPTH < 511) ? PROGRAM_DEPTH : 511;
	localparam int PCW     = $clog2(LEN_MAX + 1);
	localparam int SIW     = $clog2(STACK_DEPTH);
	localparam int SPW     = $clog2(STACK_DEPTH + 1);

	seq_state_t state_q, state_d;

	logic [PCW-1:0]     pc_q, pc_d;
	logic [SPW-1:0]     sp_q, sp_d;
	logic [GAS_W-1:0]   step_q, step_d;
	logic [1:0]         pops_q, pops_d;
	logic [BYTE_W-1:0]  op_q, op_d;
	logic [VALUE_W-1:0] opr0_q, opr0_d;
	logic [VALUE_W-1:0] opr1_q, opr1_d;
	logic [VALUE_W-1:0] opr2_q, opr2_d;
	logic               le1_q, le1_d;
	verdict_t           verdict_q, verdict_d;

	logic [PCW-1:0]     len_eff;
	logic               pc_end;
	logic [GAS_W-1:0]   step_inc;
	logic               gas_out;
	logic               sp_zero;
	logic               sp_full;
	logic               sp_lt2;
	logic [SIW-1:0]     sp_idx;
	logic [SIW-1:0]     sp_m1;
	logic [SIW-1:0]     sp_m2;

	logic               stk_we;
	logic [SIW-1:0]     stk_waddr;
	logic [VALUE_W-1:0] stk_wdata;
	logic [SIW-1:0]     stk_raddr;
	logic [VALUE_W-1:0] stk_rdata;

	logic               push_en;
	logic [VALUE_W-1:0] push_val;

	logic [VALUE_W-1:0] alu_x;
	logic [VALUE_W-1:0] alu_y;
	alu_res_t           alu_res;

	scbc_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	scbc_alu u_alu (
		.x   (alu_x),
		.y   (alu_y),
		.res (alu_res)
	);

	// Status of program counter, gas and stack pointer
	always_comb begin
		len_eff  = (32'(cfg.prog_len) > LEN_MAX) ? PCW'(LEN_MAX) : PCW'(cfg.prog_len);
		pc_end   = (pc_q >= len_eff);
		step_inc = step_q + GAS_W'(1);
		gas_out  = (step_inc >= cfg.gas);
		sp_zero  = (sp_q == '0);
		sp_full  = (sp_q >= SPW'(STACK_DEPTH));
		sp_lt2   = (sp_q < SPW'(2));
		sp_idx   = SIW'(sp_q);
		sp_m1    = SIW'(sp_q - SPW'(1));
		sp_m2    = SIW'(sp_q - SPW'(2));
	end

	assign prog_raddr = AW'(pc_q);

	// Steer the shared compare unit
	always_comb begin
		case (state_q)
			SQ_EXEC: begin
				alu_x = opr1_q;
				alu_y = opr0_q;
			end
			SQ_RANGE2: begin
				alu_x = opr0_q;
				alu_y = opr2_q;
			end
			default: begin
				alu_x = stk_rdata;
				alu_y = opr0_q;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SQ_IDLE: begin
				if (req.start) begin
					state_d = SQ_FETCH;
				end
			end
			SQ_FETCH: begin
				if (pc_end) begin
					state_d = (cfg.end_rule && !sp_zero) ? SQ_END_CHK : SQ_DONE;
				end else if (gas_out) begin
					state_d = SQ_DONE;
				end else begin
					state_d = SQ_DECODE;
				end
			end
			SQ_DECODE: begin
				case (prog_rdata)
					OPC_HALT, OPC_ASSERT, OPC_RANGE, OPC_AND, OPC_OR: state_d = SQ_POP;
					OPC_DUP:  state_d = (sp_zero || sp_full) ? SQ_DONE : SQ_DUP_WR;
					OPC_SWAP: state_d = sp_lt2 ? SQ_DONE : SQ_SWAP_RD2;
					default:  state_d = SQ_DONE;
				endcase
			end
			SQ_POP: begin
				if (!sp_zero) begin
					state_d = SQ_POP_WAIT;
				end else if (pops_q == 2'd1) begin
					state_d = SQ_EXEC;
				end
			end
			SQ_POP_WAIT: begin
				state_d = (pops_q == 2'd1) ? SQ_EXEC : SQ_POP;
			end
			SQ_EXEC: begin
				case (op_q)
					OPC_HALT:   state_d = SQ_DONE;
					OPC_ASSERT: state_d = alu_res.y_nz ? SQ_FETCH : SQ_DONE;
					OPC_RANGE:  state_d = SQ_RANGE2;
					OPC_AND:    state_d = SQ_FETCH;
					OPC_OR:     state_d = SQ_FETCH;
					default:    state_d = SQ_DONE;
				endcase
			end
			SQ_RANGE2:   state_d = SQ_FETCH;
			SQ_DUP_WR:   state_d = SQ_FETCH;
			SQ_SWAP_RD2: state_d = SQ_SWAP_WR1;
			SQ_SWAP_WR1: state_d = SQ_SWAP_WR2;
			SQ_SWAP_WR2: state_d = SQ_FETCH;
			SQ_END_CHK:  state_d = SQ_DONE;
			SQ_DONE: begin
				if (take) begin
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	// Datapath controls and register updates
	always_comb begin
		pc_d      = pc_q;
		sp_d      = sp_q;
		step_d    = step_q;
		pops_d    = pops_q;
		op_d      = op_q;
		opr0_d    = opr0_q;
		opr1_d    = opr1_q;
		opr2_d    = opr2_q;
		le1_d     = le1_q;
		verdict_d = verdict_q;
		stk_we    = 1'b0;
		stk_waddr = sp_idx;
		stk_wdata = stk_rdata;
		stk_raddr = sp_m1;
		push_en   = 1'b0;
		push_val  = '0;
		case (state_q)
			SQ_IDLE: begin
				// Seed the stack with the checked value
				if (req.start) begin
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = req.value;
					sp_d      = SPW'(1);
					pc_d      = '0;
					step_d    = '0;
				end
			end
			SQ_FETCH: begin
				if (pc_end) begin
					stk_raddr = '0;
					verdict_d = VERDICT_PASS;
				end else if (gas_out) begin
					verdict_d = VERDICT_GAS_OUT;
				end else begin
					pc_d   = pc_q + PCW'(1);
					step_d = step_inc;
				end
			end
			SQ_DECODE: begin
				op_d = prog_rdata;
				case (prog_rdata)
					OPC_HALT, OPC_ASSERT: pops_d = 2'd1;
					OPC_RANGE:            pops_d = 2'd3;
					OPC_AND, OPC_OR:      pops_d = 2'd2;
					OPC_DUP: begin
						if (sp_zero || sp_full) begin
							verdict_d = VERDICT_STACK_ERR;
						end
					end
					OPC_SWAP: begin
						if (sp_lt2) begin
							verdict_d = VERDICT_STACK_ERR;
						end
					end
					default: verdict_d = VERDICT_STACK_ERR;
				endcase
			end
			SQ_POP: begin
				// Empty stack pops as zero without a read
				if (sp_zero) begin
					opr2_d = opr1_q;
					opr1_d = opr0_q;
					opr0_d = '0;
					pops_d = pops_q - 2'd1;
				end else begin
					sp_d = sp_q - SPW'(1);
				end
			end
			SQ_POP_WAIT: begin
				opr2_d = opr1_q;
				opr1_d = opr0_q;
				opr0_d = stk_rdata;
				pops_d = pops_q - 2'd1;
			end
			SQ_EXEC: begin
				case (op_q)
					OPC_HALT: begin
						verdict_d = alu_res.y_nz ? VERDICT_ASSERT_FAIL : VERDICT_PASS;
					end
					OPC_ASSERT: begin
						verdict_d = VERDICT_ASSERT_FAIL;
					end
					OPC_RANGE: begin
						le1_d = alu_res.le;
					end
					OPC_AND: begin
						push_en  = 1'b1;
						push_val = VALUE_W'(alu_res.x_nz && alu_res.y_nz);
					end
					OPC_OR: begin
						push_en  = 1'b1;
						push_val = VALUE_W'(alu_res.x_nz || alu_res.y_nz);
					end
					default: verdict_d = VERDICT_STACK_ERR;
				endcase
			end
			SQ_RANGE2: begin
				push_en  = 1'b1;
				push_val = VALUE_W'(le1_q && alu_res.le);
			end
			SQ_DUP_WR: begin
				push_en  = 1'b1;
				push_val = stk_rdata;
			end
			SQ_SWAP_RD2: begin
				// Hold the old top, fetch the entry below it
				opr0_d    = stk_rdata;
				stk_raddr = sp_m2;
			end
			SQ_SWAP_WR1: begin
				stk_we    = 1'b1;
				stk_waddr = sp_m1;
				stk_wdata = stk_rdata;
			end
			SQ_SWAP_WR2: begin
				stk_we    = 1'b1;
				stk_waddr = sp_m2;
				stk_wdata = opr0_q;
			end
			SQ_END_CHK: begin
				verdict_d = alu_res.x_nz ? VERDICT_ASSERT_FAIL : VERDICT_PASS;
			end
			SQ_DONE: begin
			end
			default: begin
			end
		endcase

		// Push, dropped on a full stack
		if (push_en && !sp_full) begin
			stk_we    = 1'b1;
			stk_waddr = sp_idx;
			stk_wdata = push_val;
			sp_d      = sp_q + SPW'(1);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pc_q    <= '0;
			sp_q    <= '0;
			step_q  <= '0;
			pops_q  <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			sp_q    <= sp_d;
			step_q  <= step_d;
			pops_q  <= pops_d;
		end
	end

	// Operand and result registers
	always_ff @(posedge clk) begin
		op_q      <= op_d;
		opr0_q    <= opr0_d;
		opr1_q    <= opr1_d;
		opr2_q    <= opr2_d;
		le1_q     <= le1_d;
		verdict_q <= verdict_d;
	end

	assign rsp.idle    = (state_q == SQ_IDLE);
	assign rsp.done    = (state_q == SQ_DONE);
	assign rsp.verdict = verdict_q;

`ifndef NO_ASSERTIONS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_decode_after_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SQ_DECODE |-> $past(state_q) == SQ_FETCH)
		else $error("decode without a program fetch");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_DONE && !take) |=> state_q == SQ_DONE)
		else $error("result dropped before hand-off");

	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != SQ_IDLE |-> pc_q <= len_eff)
		else $error("program counter ran past program length");

	a_start_seeds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_IDLE && req.start) |=> (state_q == SQ_FETCH && sp_q == SPW'(1)))
		else $error("check did not seed the stack");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/stack_bytecode_constraint_checker.sv
// Top level: item handshake, configuration registers, program store and batch flag.
// A load item writes one program byte. A check item seeds the operand stack and
// runs the stored program one opcode at a time: a start step, then per opcode a
// program fetch and a decode plus the stack work (a pop from a non-empty stack
// takes a pop and a wait state, one from an empty stack the pop state alone; DUP
// a write state, SWAP a second read and then a write of each entry, RANGE an
// execute and a second compare state, AND/OR/HALT/ASSERT an execute state, any
// push sharing the last of these), then an optional end check and a done state
// that holds the result until it is handed over. The run time is set by the
// single read port of the operand stack memory and the one program fetch per
// opcode. The block takes no item while a check runs, but accepts the next item
// while a finished result still waits in the output register. Load items give
// no result; each check gives one, with the batch flag on the last of a batch.
`timescale 1ns / 1ps
`default_nettype none

module stack_bytecode_constraint_checker #(
	parameter int STACK_DEPTH   = 64,
	parameter int PROGRAM_DEPTH = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          chk_valid,
	output logic                               chk_ready,
	input  wire scbc_pkg::chk_item_t           chk_item,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output scbc_pkg::res_item_t                res_item,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scbc_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [scbc_pkg::PDATA_W-1:0]  pwdata,
	output logic      [scbc_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	import scbc_pkg::*;

	localparam int AW = $clog2(PROGRAM_DEPTH);
	localparam int CW = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

	cfg_t      cfg_q;
	logic      cfg_wr;
	logic [1:0] reg_idx;

	seq_req_t  req;
	seq_rsp_t  rsp;
	logic      take;

	logic      accept;
	logic      load_we;
	logic [CW-1:0] addr_ext;
	logic      addr_ok;

	logic [AW-1:0]     prog_raddr;
	logic [BYTE_W-1:0] prog_rdata;

	logic      last_q;
	logic      fail_seen_q;
	logic      fail_now;
	logic      res_valid_q;
	res_item_t res_item_q;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prog_len <= '0;
			cfg_q.gas      <= GAS_RESET;
			cfg_q.end_rule <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PROG_LEN: cfg_q.prog_len <= pwdata[PROG_LEN_W-1:0];
				REG_GAS:      cfg_q.gas      <= pwdata[GAS_W-1:0];
				REG_END_RULE: cfg_q.end_rule <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PROG_LEN: prdata = PDATA_W'(cfg_q.prog_len);
			REG_GAS:      prdata = PDATA_W'(cfg_q.gas);
			REG_END_RULE: prdata = PDATA_W'(cfg_q.end_rule);
			default:      prdata = '0;
		endcase
	end

	// Accept items while the sequencer waits for work
	assign chk_ready = rsp.idle;
	assign accept    = chk_valid && chk_ready;
	assign addr_ext  = CW'(chk_item.prog_addr);
	assign addr_ok   = (addr_ext < CW'(PROGRAM_DEPTH));
	assign load_we   = accept && (chk_item.op == OP_LOAD) && addr_ok;

	assign req.start = accept && (chk_item.op == OP_CHECK);
	assign req.value = unsigned'(chk_item.value);

	scbc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PROGRAM_DEPTH)
	) u_prog (
		.clk   (clk),
		.we    (load_we),
		.waddr (addr_ext[AW-1:0]),
		.wdata (chk_item.prog_byte),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	scbc_seq #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.take       (take),
		.rsp        (rsp),
		.prog_raddr (prog_raddr),
		.prog_rdata (prog_rdata)
	);

	// Move a finished verdict into the output register when it is free
	assign take     = rsp.done && (!res_valid_q || res_ready);
	assign fail_now = (rsp.verdict != VERDICT_PASS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			fail_seen_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (req.start) begin
				last_q <= chk_item.last_in_batch;
			end
			if (take) begin
				res_valid_q <= 1'b1;
				fail_seen_q <= last_q ? 1'b0 : (fail_seen_q || fail_now);
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_item_q.verdict      <= 2'(rsp.verdict);
			res_item_q.batch_failed <= last_q && (fail_seen_q || fail_now);
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

`default_nettype wire
